// ===== rtl/core/vn_pkg.sv =====
package vn_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DNUM_W = 56;
  localparam int ROOT_W = 33;
  localparam int RAD_W = 66;
  localparam int SREM_W = 36;
  localparam int DREM_W = 34;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_SCALE = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_NORM = 3'd4;
  localparam logic [2:0] OP_LEN = 3'd5;
  localparam logic [2:0] OP_DIST = 3'd6;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } clamp_t;

  typedef struct packed {
    logic [2:0]          op;
    logic [31:0]         vx;
    logic [31:0]         vy;
    logic [1:0]          vst;
    logic                negx;
    logic                negy;
    logic [RAD_W-1:0]    rad;
    logic [SREM_W-1:0]   srem;
    logic [ROOT_W-1:0]   root;
    logic [ROOT_W-1:0]   dvs;
    logic [DNUM_W-1:0]   numx;
    logic [DNUM_W-1:0]   numy;
    logic [DREM_W-1:0]   dremx;
    logic [DREM_W-1:0]   dremy;
    logic [DNUM_W-1:0]   qx;
    logic [DNUM_W-1:0]   qy;
  } pipe_t;

  function automatic clamp_t clamp65(input logic signed [64:0] v);
    clamp_t c;
    if (v > 65'sd2147483647) begin
      c.val = 32'h7FFF_FFFF;
      c.sat = 1'b1;
    end else if (v < -65'sd2147483648) begin
      c.val = 32'h8000_0000;
      c.sat = 1'b1;
    end else begin
      c.val = v[31:0];
      c.sat = 1'b0;
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/vector2d_arith_normalize_unit.sv =====
// 2D vector unit, signed fixed point with FRAC_BITS fraction bits.
// Input channel: in_valid/in_stall carry op, a_x, a_y, b_x, b_y, scalar.
// Output channel: out_valid/out_stall carry r_x, r_y, magnitude, status.
// Ops: add, sub, scale, divide, normalize, length, distance.
// One item enters per cycle and one result leaves per cycle while the output is not stalled.
// The chain is 2 front stages, 33 square-root cells, (32 + FRAC_BITS)
// divider cells and 1 output stage.
// Every item walks the whole chain: the sqrt cells resolve two radicand
// bits each, the divider cells one quotient bit each, for x and y side by
// side. Divide and normalize share the divider row.
// A stalled output freezes the whole chain; in_stall is raised in that
// same cycle, so nothing is lost or repeated.
// Reset clears all valid flags; payload registers come up unknown and
// are never shown.
module vector2d_arith_normalize_unit #(
  parameter int FRAC_BITS = vn_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         op,
  input  logic signed [31:0] a_x,
  input  logic signed [31:0] a_y,
  input  logic signed [31:0] b_x,
  input  logic signed [31:0] b_y,
  input  logic signed [31:0] scalar,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] r_x,
  output logic signed [31:0] r_y,
  output logic [32:0]        magnitude,
  output logic [1:0]         status
);

  localparam int NSQ = vn_pkg::ROOT_W;
  localparam int NDV = 32 + FRAC_BITS;
  localparam int LAT = 2 + NSQ + NDV + 1;

  logic [LAT-1:0] vld;
  logic           adv;
  vn_pkg::pipe_t  sq_p [NSQ+1];
  vn_pkg::pipe_t  dv_p [NDV+1];
  vn_pkg::pipe_t  dv_in;

  assign adv = !(vld[LAT-1] && out_stall);
  assign in_stall = !adv;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  vn_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .en(adv), .op(op), .a_x(a_x), .a_y(a_y), .b_x(b_x), .b_y(b_y),
    .scalar(scalar), .q(sq_p[0])
  );

  for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
    vn_sqrt_cell u_cell (.clk(clk), .en(adv), .d(sq_p[i]), .q(sq_p[i+1]));
  end

  always_comb begin
    dv_in = sq_p[NSQ];
    if (sq_p[NSQ].op == vn_pkg::OP_NORM) begin
      dv_in.dvs = sq_p[NSQ].root;
    end
  end

  assign dv_p[0] = dv_in;

  for (genvar j = 0; j < NDV; j++) begin : g_div
    vn_div_cell u_cell (.clk(clk), .en(adv), .d(dv_p[j]), .q(dv_p[j+1]));
  end

  vn_back u_back (
    .clk(clk), .en(adv), .d(dv_p[NDV]), .r_x(r_x), .r_y(r_y),
    .magnitude(magnitude), .status(status)
  );

`ifndef ASSERT_OFF
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status != 2'd3))
    else $error("undefined status code");
  a_mag_only: assert property (@(posedge clk) disable iff (rst)
    (out_valid && magnitude != '0) |-> (r_x == '0 && r_y == '0 && status == vn_pkg::ST_OK))
    else $error("magnitude result with vector fields");
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> vld[0])
    else $error("accepted item not tracked");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (vld == $past(vld)))
    else $error("chain moved under stall");
`endif

endmodule

// ===== rtl/core/vn_front.sv =====
module vn_front #(
  parameter int FRAC_BITS = vn_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                en,
  input  logic [2:0]          op,
  input  logic signed [31:0]  a_x,
  input  logic signed [31:0]  a_y,
  input  logic signed [31:0]  b_x,
  input  logic signed [31:0]  b_y,
  input  logic signed [31:0]  scalar,
  output vn_pkg::pipe_t       q
);

  logic signed [32:0] sum_x, sum_y, dx, dy;
  logic [33:0]        ndx, ndy;
  logic [32:0]        ux, uy;
  logic [32:0]        na_x, na_y, n_s;

  logic [2:0]           s1_op;
  vn_pkg::clamp_t       s1_addx, s1_addy;
  logic signed [63:0]   s1_px, s1_py;
  logic [65:0]          s1_sx, s1_sy;
  logic [31:0]          s1_aax, s1_aay, s1_as;
  logic                 s1_nx, s1_ny, s1_ns, s1_zx, s1_zy, s1_zs;

  logic signed [64:0] half, vx65, vy65, shx, shy;
  vn_pkg::clamp_t     scx, scy;
  vn_pkg::pipe_t      q_next;

  always_comb begin
    if (op == vn_pkg::OP_SUB) begin
      sum_x = 33'(a_x) - 33'(b_x);
      sum_y = 33'(a_y) - 33'(b_y);
    end else begin
      sum_x = 33'(a_x) + 33'(b_x);
      sum_y = 33'(a_y) + 33'(b_y);
    end
    if (op == vn_pkg::OP_DIST) begin
      dx = 33'(a_x) - 33'(b_x);
      dy = 33'(a_y) - 33'(b_y);
    end else begin
      dx = 33'(a_x);
      dy = 33'(a_y);
    end
    ndx = -{dx[32], dx};
    ndy = -{dy[32], dy};
    ux = dx[32] ? ndx[32:0] : dx;
    uy = dy[32] ? ndy[32:0] : dy;
    na_x = -{a_x[31], a_x};
    na_y = -{a_y[31], a_y};
    n_s = -{scalar[31], scalar};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op <= op;
      s1_addx <= vn_pkg::clamp65(65'(sum_x));
      s1_addy <= vn_pkg::clamp65(65'(sum_y));
      s1_px <= 64'(a_x) * 64'(scalar);
      s1_py <= 64'(a_y) * 64'(scalar);
      s1_sx <= 66'(ux) * 66'(ux);
      s1_sy <= 66'(uy) * 66'(uy);
      s1_aax <= a_x[31] ? na_x[31:0] : a_x;
      s1_aay <= a_y[31] ? na_y[31:0] : a_y;
      s1_as <= scalar[31] ? n_s[31:0] : scalar;
      s1_nx <= a_x[31];
      s1_ny <= a_y[31];
      s1_ns <= scalar[31];
      s1_zx <= (a_x == 32'sd0);
      s1_zy <= (a_y == 32'sd0);
      s1_zs <= (scalar == 32'sd0);
    end
  end

  always_comb begin
    half = 65'sd1 <<< (FRAC_BITS - 1);
    vx65 = 65'(s1_px) + half;
    vy65 = 65'(s1_py) + half;
    shx = vx65 >>> FRAC_BITS;
    shy = vy65 >>> FRAC_BITS;
    scx = vn_pkg::clamp65(shx);
    scy = vn_pkg::clamp65(shy);

    q_next = '0;
    q_next.op = s1_op;
    q_next.rad = s1_sx + s1_sy;
    q_next.dvs = {1'b0, s1_as};
    q_next.numx = {s1_aax, 24'd0};
    q_next.numy = {s1_aay, 24'd0};
    q_next.negx = (s1_op == vn_pkg::OP_DIV) ? (s1_nx ^ s1_ns) : s1_nx;
    q_next.negy = (s1_op == vn_pkg::OP_DIV) ? (s1_ny ^ s1_ns) : s1_ny;
    q_next.vst = vn_pkg::ST_OK;
    case (s1_op)
      vn_pkg::OP_ADD, vn_pkg::OP_SUB: begin
        q_next.vx = s1_addx.val;
        q_next.vy = s1_addy.val;
        q_next.vst = (s1_addx.sat || s1_addy.sat) ? vn_pkg::ST_SAT : vn_pkg::ST_OK;
      end
      vn_pkg::OP_SCALE: begin
        q_next.vx = scx.val;
        q_next.vy = scy.val;
        q_next.vst = (scx.sat || scy.sat) ? vn_pkg::ST_SAT : vn_pkg::ST_OK;
      end
      vn_pkg::OP_DIV: begin
        if (s1_zs) begin
          q_next.vx = s1_zx ? 32'd0 : (s1_nx ? 32'h8000_0000 : 32'h7FFF_FFFF);
          q_next.vy = s1_zy ? 32'd0 : (s1_ny ? 32'h8000_0000 : 32'h7FFF_FFFF);
          q_next.vst = vn_pkg::ST_DIV0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

// ===== rtl/core/vn_sqrt_cell.sv =====
module vn_sqrt_cell (
  input  logic          clk,
  input  logic          en,
  input  vn_pkg::pipe_t d,
  output vn_pkg::pipe_t q
);

  logic [vn_pkg::SREM_W-1:0] rem_s, trial;
  vn_pkg::pipe_t             q_next;

  always_comb begin
    rem_s = {d.srem[vn_pkg::SREM_W-3:0], d.rad[vn_pkg::RAD_W-1 -: 2]};
    trial = {1'b0, d.root, 2'b01};
    q_next = d;
    q_next.rad = {d.rad[vn_pkg::RAD_W-3:0], 2'b00};
    if (rem_s >= trial) begin
      q_next.srem = rem_s - trial;
      q_next.root = {d.root[vn_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      q_next.srem = rem_s;
      q_next.root = {d.root[vn_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

// ===== rtl/core/vn_div_cell.sv =====
module vn_div_cell (
  input  logic          clk,
  input  logic          en,
  input  vn_pkg::pipe_t d,
  output vn_pkg::pipe_t q
);

  logic [vn_pkg::DREM_W-1:0] rx, ry, dv;
  vn_pkg::pipe_t             q_next;

  always_comb begin
    dv = {1'b0, d.dvs};
    rx = {d.dremx[vn_pkg::DREM_W-2:0], d.numx[vn_pkg::DNUM_W-1]};
    ry = {d.dremy[vn_pkg::DREM_W-2:0], d.numy[vn_pkg::DNUM_W-1]};
    q_next = d;
    q_next.numx = {d.numx[vn_pkg::DNUM_W-2:0], 1'b0};
    q_next.numy = {d.numy[vn_pkg::DNUM_W-2:0], 1'b0};
    if (rx >= dv) begin
      q_next.dremx = rx - dv;
      q_next.qx = {d.qx[vn_pkg::DNUM_W-2:0], 1'b1};
    end else begin
      q_next.dremx = rx;
      q_next.qx = {d.qx[vn_pkg::DNUM_W-2:0], 1'b0};
    end
    if (ry >= dv) begin
      q_next.dremy = ry - dv;
      q_next.qy = {d.qy[vn_pkg::DNUM_W-2:0], 1'b1};
    end else begin
      q_next.dremy = ry;
      q_next.qy = {d.qy[vn_pkg::DNUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

// ===== rtl/core/vn_back.sv =====
module vn_back (
  input  logic          clk,
  input  logic          en,
  input  vn_pkg::pipe_t d,
  output logic [31:0]   r_x,
  output logic [31:0]   r_y,
  output logic [32:0]   magnitude,
  output logic [1:0]    status
);

  vn_pkg::clamp_t cx, cy;
  logic [31:0]    rx_next, ry_next;
  logic [32:0]    mag_next;
  logic [1:0]     st_next;

  function automatic vn_pkg::clamp_t qclamp(input logic [vn_pkg::DNUM_W-1:0] qv,
                                            input logic neg);
    vn_pkg::clamp_t c;
    if (neg) begin
      if (qv[vn_pkg::DNUM_W-1:32] != '0 || (qv[31] && qv[30:0] != '0)) begin
        c.val = 32'h8000_0000;
        c.sat = 1'b1;
      end else begin
        c.val = ~qv[31:0] + 32'd1;
        c.sat = 1'b0;
      end
    end else begin
      if (qv[vn_pkg::DNUM_W-1:31] != '0) begin
        c.val = 32'h7FFF_FFFF;
        c.sat = 1'b1;
      end else begin
        c.val = qv[31:0];
        c.sat = 1'b0;
      end
    end
    return c;
  endfunction

  always_comb begin
    cx = qclamp(d.qx, d.negx);
    cy = qclamp(d.qy, d.negy);
    rx_next = d.vx;
    ry_next = d.vy;
    mag_next = '0;
    st_next = d.vst;
    case (d.op)
      vn_pkg::OP_DIV: begin
        if (d.vst != vn_pkg::ST_DIV0) begin
          rx_next = cx.val;
          ry_next = cy.val;
          st_next = (cx.sat || cy.sat) ? vn_pkg::ST_SAT : vn_pkg::ST_OK;
        end
      end
      vn_pkg::OP_NORM: begin
        if (d.root != '0) begin
          rx_next = cx.val;
          ry_next = cy.val;
        end
        st_next = vn_pkg::ST_OK;
      end
      vn_pkg::OP_LEN, vn_pkg::OP_DIST: begin
        mag_next = d.root;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_x <= rx_next;
      r_y <= ry_next;
      magnitude <= mag_next;
      status <= st_next;
    end
  end

endmodule
